[rtl/servo_sync_write_packet_framer_top_defines.svh]
// Assertion macros for the packet framer checker.
`ifndef SERVO_SYNC_WRITE_PACKET_FRAMER_TOP_DEFINES_SVH
`define SERVO_SYNC_WRITE_PACKET_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSWPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSWPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define SSWPF_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sswpf_pkg.sv]
`default_nettype none
package sswpf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_SINGLE = 2'd0;
  localparam logic [1:0] OP_GROUP  = 2'd1;
  localparam logic [1:0] OP_IDW    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_GROUP  = 2'd1;
  localparam logic [1:0] KIND_IDW    = 2'd2;

  localparam logic [1:0] REG_SINGLE_SPEED   = 2'd0;
  localparam logic [1:0] REG_GROUP_SPEED    = 2'd1;
  localparam logic [1:0] REG_GROUP_FIRST_ID = 2'd2;
  localparam logic [1:0] REG_GROUP_COUNT    = 2'd3;

  localparam logic [15:0] SINGLE_SPEED_RST   = 16'h0078;
  localparam logic [15:0] GROUP_SPEED_RST    = 16'd1023;
  localparam logic [7:0]  GROUP_FIRST_ID_RST = 8'd2;
  localparam logic [5:0]  GROUP_COUNT_RST    = 6'd20;

  localparam logic [7:0] BYTE_SYNC      = 8'hFF;
  localparam logic [7:0] BYTE_BCAST     = 8'hFE;
  localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
  localparam logic [7:0] ADDR_GOAL      = 8'h1E;
  localparam logic [7:0] DATA_LEN       = 8'h04;
  localparam logic [7:0] INS_WRITE      = 8'h03;
  localparam logic [7:0] ADDR_ID        = 8'h03;
  localparam logic [7:0] LEN_SINGLE     = 8'h09;
  localparam logic [7:0] LEN_IDW        = 8'h04;
  localparam logic [7:0] LEN_BASE       = 8'h04;

  typedef struct packed {
    logic [1:0]  kind;
    logic        hdr;
    logic        close;
    logic [7:0]  id;
    logic [15:0] pos;
    logic [15:0] speed;
    logic [7:0]  len;
  } desc_t;

endpackage
`default_nettype wire

[rtl/servo_sync_write_packet_framer_top.sv]
`default_nettype none
// Servo bus instruction packet framer. Each accepted item becomes packet bytes on the out
// channel, one byte per transfer, in wire order: op 0 gives a 13-byte sync-write packet,
// op 2 an 8-byte ID-write packet, op 1 one group entry of 5 bytes, plus the 7-byte header
// on the first entry and the checksum byte on the final one (5 to 13 bytes), and op 3
// gives nothing and only drops a partly sent group. Bytes leave through the single byte
// register on the out channel and flow without gaps from one item to the next while
// out_ready stays high and the next item is queued. Items are classified on entry and
// held in a descriptor queue of QueueDepth entries, so up to QueueDepth items are taken
// while an earlier packet is still streaming; in_ready then drops until the back end
// starts the next one. Write configuration registers only while no bytes are pending.
module servo_sync_write_packet_framer_top #(
  parameter int QueueDepth = sswpf_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_op,
  input  wire  [7:0]  in_servo_id,
  input  wire  [15:0] in_position,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_packet_end,
  output logic        out_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import sswpf_pkg::*;

  logic  push;
  desc_t push_desc;
  logic  q_ready;
  logic  q_valid;
  desc_t q_desc;
  logic  pop;

  sswpf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_servo_id (in_servo_id),
    .in_position (in_position),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .push_desc   (push_desc),
    .q_ready     (q_ready)
  );

  sswpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .pop       (pop)
  );

  sswpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_desc         (q_desc),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_byte    (out_tx_byte),
    .out_packet_end (out_packet_end),
    .out_last       (out_last)
  );
endmodule
`default_nettype wire

[rtl/sswpf_front.sv]
`default_nettype none
module sswpf_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          in_op,
  input  wire  [7:0]          in_servo_id,
  input  wire  [15:0]         in_position,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data,
  output logic                push,
  output sswpf_pkg::desc_t    push_desc,
  input  wire                 q_ready
);
  import sswpf_pkg::*;

  logic [15:0] single_speed_r;
  logic [15:0] group_speed_r;
  logic [7:0]  group_first_id_r;
  logic [5:0]  group_count_r;
  logic [5:0]  gidx_r;
  logic [5:0]  gidx_nxt;
  logic        accept;
  logic        gclose;
  logic [7:0]  glen;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (in_op != OP_NONE);

  assign gclose = ({1'b0, gidx_r} + 7'd1) >= {1'b0, group_count_r};
  assign glen   = {group_count_r, 2'b00} + {2'b00, group_count_r} + LEN_BASE;

  always_comb begin
    push_desc       = '0;
    push_desc.pos   = in_position;
    push_desc.id    = in_servo_id;
    push_desc.hdr   = 1'b1;
    push_desc.close = 1'b1;
    gidx_nxt        = gidx_r;
    case (in_op)
      OP_SINGLE: begin
        push_desc.kind  = KIND_SINGLE;
        push_desc.speed = single_speed_r;
        push_desc.len   = LEN_SINGLE;
        gidx_nxt        = '0;
      end
      OP_GROUP: begin
        push_desc.kind  = KIND_GROUP;
        push_desc.speed = group_speed_r;
        push_desc.len   = glen;
        push_desc.id    = group_first_id_r + {2'b00, gidx_r};
        push_desc.hdr   = (gidx_r == '0);
        push_desc.close = gclose;
        gidx_nxt        = gclose ? '0 : gidx_r + 6'd1;
      end
      OP_IDW: begin
        push_desc.kind = KIND_IDW;
        push_desc.len  = LEN_IDW;
        gidx_nxt       = '0;
      end
      default: begin
        push_desc.kind = KIND_IDW;
        gidx_nxt       = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_speed_r   <= SINGLE_SPEED_RST;
      group_speed_r    <= GROUP_SPEED_RST;
      group_first_id_r <= GROUP_FIRST_ID_RST;
      group_count_r    <= GROUP_COUNT_RST;
      gidx_r           <= '0;
    end else begin
      if (accept) gidx_r <= gidx_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SINGLE_SPEED:   single_speed_r   <= cfg_data;
          REG_GROUP_SPEED:    group_speed_r    <= cfg_data;
          REG_GROUP_FIRST_ID: group_first_id_r <= cfg_data[7:0];
          REG_GROUP_COUNT:    group_count_r    <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[rtl/sswpf_queue.sv]
`default_nettype none
module sswpf_queue #(
  parameter int Depth = sswpf_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  sswpf_pkg::desc_t    push_desc,
  output logic                q_ready,
  output logic                q_valid,
  output sswpf_pkg::desc_t    q_desc,
  input  wire                 pop
);
  import sswpf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t           slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign q_ready = (count_r != CntW'(Depth));
  assign q_valid = (count_r != '0);
  assign q_desc  = slot_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + CntW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CntW'(1);
    end
  end
endmodule
`default_nettype wire

[rtl/sswpf_back.sv]
`default_nettype none
module sswpf_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  sswpf_pkg::desc_t    q_desc,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_tx_byte,
  output logic                out_packet_end,
  output logic                out_last
);
  import sswpf_pkg::*;

  localparam logic [3:0] STEP_SYNC0  = 4'd0;
  localparam logic [3:0] STEP_SYNC1  = 4'd1;
  localparam logic [3:0] STEP_BCAST  = 4'd2;
  localparam logic [3:0] STEP_LEN    = 4'd3;
  localparam logic [3:0] STEP_INS    = 4'd4;
  localparam logic [3:0] STEP_ADDR   = 4'd5;
  localparam logic [3:0] STEP_DLEN   = 4'd6;
  localparam logic [3:0] STEP_ID     = 4'd7;
  localparam logic [3:0] STEP_POS_LO = 4'd8;
  localparam logic [3:0] STEP_POS_HI = 4'd9;
  localparam logic [3:0] STEP_SPD_LO = 4'd10;
  localparam logic [3:0] STEP_SPD_HI = 4'd11;
  localparam logic [3:0] STEP_CK     = 4'd12;

  desc_t      desc_r;
  logic       busy_r;
  logic [3:0] step_r;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic       out_valid_r;
  logic [7:0] tx_byte_r;
  logic       packet_end_r;
  logic       last_r;
  logic [7:0] cur_byte;
  logic       is_idw;
  logic       ck_step;
  logic       is_last;
  logic       summed;
  logic       out_free;
  logic       adv;

  assign is_idw   = (desc_r.kind == KIND_IDW);
  assign ck_step  = is_idw ? (step_r == STEP_ID) : (step_r == STEP_CK);
  assign is_last  = ck_step
                 || ((desc_r.kind == KIND_GROUP) && !desc_r.close && (step_r == STEP_SPD_HI));
  assign summed   = (step_r >= STEP_BCAST) && !ck_step;
  assign out_free = !out_valid_r || out_ready;
  assign adv      = busy_r && out_free;
  assign pop      = q_valid && (!busy_r || (adv && is_last));

  always_comb begin
    case (step_r)
      STEP_SYNC0:  cur_byte = BYTE_SYNC;
      STEP_SYNC1:  cur_byte = BYTE_SYNC;
      STEP_BCAST:  cur_byte = BYTE_BCAST;
      STEP_LEN:    cur_byte = desc_r.len;
      STEP_INS:    cur_byte = is_idw ? INS_WRITE : INS_SYNC_WRITE;
      STEP_ADDR:   cur_byte = is_idw ? ADDR_ID : ADDR_GOAL;
      STEP_DLEN:   cur_byte = is_idw ? desc_r.id : DATA_LEN;
      STEP_ID:     cur_byte = is_idw ? ~sum_r : desc_r.id;
      STEP_POS_LO: cur_byte = desc_r.pos[7:0];
      STEP_POS_HI: cur_byte = desc_r.pos[15:8];
      STEP_SPD_LO: cur_byte = desc_r.speed[7:0];
      STEP_SPD_HI: cur_byte = desc_r.speed[15:8];
      STEP_CK:     cur_byte = ~sum_r;
      default:     cur_byte = BYTE_SYNC;
    endcase
  end

  always_comb begin
    sum_nxt = sum_r;
    if (adv && (step_r == STEP_BCAST)) sum_nxt = cur_byte;
    else if (adv && summed)            sum_nxt = sum_r + cur_byte;
  end

  always_ff @(posedge clk) begin
    if (pop) desc_r <= q_desc;
    if (adv) begin
      tx_byte_r    <= cur_byte;
      packet_end_r <= ck_step;
      last_r       <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_SYNC0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      if (pop) begin
        busy_r <= 1'b1;
        step_r <= ((q_desc.kind == KIND_GROUP) && !q_desc.hdr) ? STEP_ID : STEP_SYNC0;
      end else if (adv && is_last) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        step_r <= step_r + 4'd1;
      end
      if (adv)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_byte    = tx_byte_r;
  assign out_packet_end = packet_end_r;
  assign out_last       = last_r;
endmodule
`default_nettype wire

[rtl/sswpf_chk.sv]
`default_nettype none
`include "servo_sync_write_packet_framer_top_defines.svh"
module sswpf_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_tx_byte,
  input wire       out_packet_end,
  input wire       out_last
);
  `SSWPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tx_byte) && $stable(out_packet_end) && $stable(out_last), "stalled byte changed")
  `SSWPF_ASSERT_NOW(a_end_is_last, out_valid && out_packet_end, out_last, "checksum byte not last of its item")
  `SSWPF_ASSERT_RST(a_rst_clears, !rst_n, !out_valid, "out_valid set after reset")
endmodule

bind servo_sync_write_packet_framer_top sswpf_chk u_chk (.*);
`default_nettype wire

[test/servo_sync_write_packet_framer_top_tb.sv]
`timescale 1ns / 1ps
module servo_sync_write_packet_framer_top_tb;
  import sswpf_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 6;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  op;
    logic [7:0]  servo_id;
    logic [15:0] position;
    logic        chk_on;
    logic [7:0]  chk;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
    logic       last;
  } tx_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [7:0]  in_servo_id;
  logic [15:0] in_position;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_tx_byte;
  logic        out_packet_end;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  logic        row_chk_on;
  logic [7:0]  row_chk;

  logic [15:0] spd_single;
  logic [15:0] spd_group;
  logic [7:0]  first_id;
  logic [5:0]  grp_count;
  logic [5:0]  grp_idx;
  logic [7:0]  grp_sum;

  logic [7:0]  pkt_buf [0:12];
  int          pkt_len;
  logic [7:0]  pkt_sum;

  tx_rec_t     tx_expect [$];
  stim_row_t   dir_rows [$];
  int          mismatches = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [5:0]  cur_count;

  servo_sync_write_packet_framer_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_servo_id    (in_servo_id),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_byte    (out_tx_byte),
    .out_packet_end (out_packet_end),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic put_byte(input logic [7:0] b, input bit summed);
    pkt_buf[pkt_len] = b;
    pkt_len++;
    if (summed) pkt_sum = pkt_sum + b;
  endtask

  task automatic frame_item(input logic [1:0] op, input logic [7:0] id,
                            input logic [15:0] pos, input bit chk_on,
                            input logic [7:0] chk);
    bit      closes;
    tx_rec_t rec;
    closes = 1'b0;
    pkt_len = 0;
    if (op == OP_GROUP) begin
      pkt_sum = grp_sum;
      if (grp_idx == 6'd0) begin
        pkt_sum = 8'd0;
        put_byte(BYTE_SYNC, 1'b0);
        put_byte(BYTE_SYNC, 1'b0);
        put_byte(BYTE_BCAST, 1'b1);
        put_byte(8'((5 * int'(grp_count) + 4) & 255), 1'b1);
        put_byte(INS_SYNC_WRITE, 1'b1);
        put_byte(ADDR_GOAL, 1'b1);
        put_byte(DATA_LEN, 1'b1);
      end
      put_byte(8'((int'(first_id) + int'(grp_idx)) & 255), 1'b1);
      put_byte(pos[7:0], 1'b1);
      put_byte(pos[15:8], 1'b1);
      put_byte(spd_group[7:0], 1'b1);
      put_byte(spd_group[15:8], 1'b1);
      if (int'(grp_idx) + 1 >= int'(grp_count)) begin
        closes = 1'b1;
        grp_idx = 6'd0;
        grp_sum = 8'd0;
      end else begin
        grp_idx = grp_idx + 6'd1;
        grp_sum = pkt_sum;
      end
    end else begin
      grp_idx = 6'd0;
      grp_sum = 8'd0;
      pkt_sum = 8'd0;
      if (op == OP_SINGLE) begin
        put_byte(BYTE_SYNC, 1'b0);
        put_byte(BYTE_SYNC, 1'b0);
        put_byte(BYTE_BCAST, 1'b1);
        put_byte(LEN_SINGLE, 1'b1);
        put_byte(INS_SYNC_WRITE, 1'b1);
        put_byte(ADDR_GOAL, 1'b1);
        put_byte(DATA_LEN, 1'b1);
        put_byte(id, 1'b1);
        put_byte(pos[7:0], 1'b1);
        put_byte(pos[15:8], 1'b1);
        put_byte(spd_single[7:0], 1'b1);
        put_byte(spd_single[15:8], 1'b1);
        closes = 1'b1;
      end else if (op == OP_IDW) begin
        put_byte(BYTE_SYNC, 1'b0);
        put_byte(BYTE_SYNC, 1'b0);
        put_byte(BYTE_BCAST, 1'b1);
        put_byte(LEN_IDW, 1'b1);
        put_byte(INS_WRITE, 1'b1);
        put_byte(ADDR_ID, 1'b1);
        put_byte(id, 1'b1);
        closes = 1'b1;
      end
    end
    if (closes) put_byte(chk_on ? chk : ~pkt_sum, 1'b0);
    for (int i = 0; i < pkt_len; i++) begin
      rec.tx_byte = pkt_buf[i];
      rec.packet_end = closes && (i == pkt_len - 1);
      rec.last = (i == pkt_len - 1);
      tx_expect.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    tx_rec_t want;
    if (rst_n !== 1'b1) begin
      spd_single = SINGLE_SPEED_RST;
      spd_group = GROUP_SPEED_RST;
      first_id = GROUP_FIRST_ID_RST;
      grp_count = GROUP_COUNT_RST;
      grp_idx = 6'd0;
      grp_sum = 8'd0;
    end else begin
      if (in_valid === 1'b1 && in_ready === 1'b1)
        frame_item(in_op, in_servo_id, in_position, row_chk_on, row_chk);
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_SINGLE_SPEED:   spd_single = cfg_data;
          REG_GROUP_SPEED:    spd_group = cfg_data;
          REG_GROUP_FIRST_ID: first_id = cfg_data[7:0];
          REG_GROUP_COUNT:    grp_count = cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (tx_expect.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte %02h", $time,
                   out_tx_byte);
          mismatches++;
        end else begin
          want = tx_expect.pop_front();
          if (out_tx_byte !== want.tx_byte) begin
            $display("%0t: tx_byte expected %02h actual %02h", $time, want.tx_byte,
                     out_tx_byte);
            mismatches++;
          end
          if (out_packet_end !== want.packet_end) begin
            $display("%0t: packet_end expected %0b actual %0b", $time, want.packet_end,
                     out_packet_end);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !(out_idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] id, input logic [15:0] pos,
                          input logic chk_on, input logic [7:0] chk);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.servo_id = id;
    row.position = pos;
    row.chk_on = chk_on;
    row.chk = chk;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] id, input logic [15:0] pos,
                           input logic chk_on, input logic [7:0] chk);
    if (in_idle_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_servo_id <= id;
    in_position <= pos;
    row_chk_on <= chk_on;
    row_chk <= chk;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tx_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_GROUP_COUNT) cur_count = val[5:0];
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_id();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd253;
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic cfg_random();
    logic [7:0] fid;
    logic [5:0] cnt;
    case ($urandom_range(0, 9))
      0: cnt = 6'd0;
      1: cnt = 6'd1;
      2: cnt = 6'd2;
      3: cnt = 6'd3;
      4: cnt = 6'd50;
      5: cnt = 6'd63;
      6: cnt = 6'($urandom_range(1, 50));
      default: cnt = 6'($urandom_range(1, 8));
    endcase
    fid = rand_id();
    write_reg(REG_SINGLE_SPEED, rand_word());
    write_reg(REG_GROUP_SPEED, rand_word());
    write_reg(REG_GROUP_FIRST_ID, {8'($urandom_range(0, 255)), fid});
    write_reg(REG_GROUP_COUNT, {10'($urandom_range(0, 1023)), cnt});
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_item(OP_SINGLE, rand_id(), rand_word(), 1'b0, 8'd0);
      1: send_item(OP_IDW, rand_id(), rand_word(), 1'b0, 8'd0);
      default: send_item(OP_NONE, rand_id(), rand_word(), 1'b0, 8'd0);
    endcase
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int r;
    int k;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = (cur_count == 6'd0) ? 1 : int'(cur_count);
        if ($urandom_range(0, 7) == 0) k = $urandom_range(1, k);
        repeat (k) send_item(OP_GROUP, rand_id(), rand_word(), 1'b0, 8'd0);
        sent += k;
        if (k < int'(cur_count)) begin
          send_noise();
          sent++;
        end
      end else if (r < 75) begin
        send_item(OP_SINGLE, rand_id(), rand_word(), 1'b0, 8'd0);
        sent++;
      end else if (r < 88) begin
        send_item(OP_IDW, rand_id(), rand_word(), 1'b0, 8'd0);
        sent++;
      end else begin
        send_item(OP_NONE, rand_id(), rand_word(), 1'b0, 8'd0);
        sent++;
      end
    end
  endtask

  initial begin
    int wait_cnt;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_SINGLE;
    in_servo_id <= 8'd0;
    in_position <= 16'd0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SINGLE_SPEED;
    cfg_data <= 16'd0;
    row_chk_on <= 1'b0;
    row_chk <= 8'd0;
    cur_count = GROUP_COUNT_RST;

    add_item(OP_SINGLE, 8'd0, 16'h0000, 1'b1, 8'hDB);
    add_item(OP_SINGLE, 8'd253, 16'hFFFF, 1'b1, 8'hE0);
    add_item(OP_IDW, 8'd0, 16'hFFFF, 1'b1, 8'hF7);
    add_item(OP_IDW, 8'd253, 16'h0000, 1'b1, 8'hFA);
    add_item(OP_NONE, 8'hFF, 16'hFFFF, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'h1234, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'hABCD, 1'b0, 8'd0);
    add_item(OP_NONE, 8'd0, 16'h0000, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'h00FF, 1'b0, 8'd0);
    add_item(OP_SINGLE, 8'hFF, 16'h5A5A, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'hFF00, 1'b0, 8'd0);
    add_item(OP_IDW, 8'hFF, 16'h0000, 1'b0, 8'd0);
    add_cfg(REG_SINGLE_SPEED, 16'h0000);
    add_cfg(REG_GROUP_SPEED, 16'h0000);
    add_cfg(REG_GROUP_FIRST_ID, 16'h0000);
    add_cfg(REG_GROUP_COUNT, 16'h0001);
    add_item(OP_GROUP, 8'd0, 16'h0000, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'hFFFF, 1'b0, 8'd0);
    add_item(OP_SINGLE, 8'd0, 16'h0000, 1'b0, 8'd0);
    add_cfg(REG_SINGLE_SPEED, 16'hFFFF);
    add_cfg(REG_GROUP_SPEED, 16'hFFFF);
    add_cfg(REG_GROUP_FIRST_ID, 16'hFFFD);
    add_cfg(REG_GROUP_COUNT, 16'hFFC0);
    add_item(OP_GROUP, 8'd0, 16'hFFFF, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'h0000, 1'b0, 8'd0);
    add_item(OP_SINGLE, 8'd253, 16'hFFFF, 1'b0, 8'd0);
    add_cfg(REG_GROUP_FIRST_ID, 16'h00FA);
    add_cfg(REG_GROUP_COUNT, 16'd50);
    add_cfg(REG_GROUP_SPEED, 16'hA5A5);
    add_cfg(REG_SINGLE_SPEED, 16'h5A5A);
    add_item(OP_GROUP, 8'd0, 16'h8001, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'h7FFE, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'hC33C, 1'b0, 8'd0);
    add_cfg(REG_GROUP_COUNT, 16'd2);
    add_item(OP_GROUP, 8'd0, 16'h0F0F, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'hF0F0, 1'b0, 8'd0);
    add_item(OP_GROUP, 8'd0, 16'h3C3C, 1'b0, 8'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        send_item(dir_rows[i].op, dir_rows[i].servo_id, dir_rows[i].position,
                  dir_rows[i].chk_on, dir_rows[i].chk);
    end

    for (int ph = 0; ph < 6; ph++) begin
      cfg_random();
      in_idle_on = (ph != 2);
      out_idle_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      run_phase(25);
      if (ph == 3) drain();
      run_phase(25);
    end

    in_valid <= 1'b0;
    wait_cnt = 0;
    @(posedge clk);
    while (tx_expect.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tx_expect.size() != 0) begin
      $display("%0t: transfers outstanding, expected 0 actual %0d", $time, tx_expect.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
